[hdl/assert_macros.svh]
// Assertion macros shared by the RTL files of the paren run block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed: condition does not hold");

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication does not hold");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication does not hold");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, cond)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[hdl/lvpr_pkg.sv]
// Package with constants and control types for the paren run block.
`default_nettype none

package lvpr_pkg;

    localparam int DEF_STACK_DEPTH = 1024;
    localparam int DEF_MAX_STRING  = 65535;

    localparam int SYM_W    = 8;
    localparam int LEN_W    = 16;
    localparam int ENTRY_W  = LEN_W + 1;
    localparam int OPEN_BIT = LEN_W;

    localparam logic [SYM_W-1:0] OPEN_CHAR = 8'h28;

    typedef struct packed {
        logic               push;
        logic               pop;
        logic               clear;
        logic [ENTRY_W-1:0] entry;
    } stk_ctl_t;

    typedef struct packed {
        logic             full;
        logic             single;
        logic             top_open;
        logic [LEN_W-1:0] second_pos;
    } stk_stat_t;

endpackage

`default_nettype wire

[hdl/longest_valid_paren_run.sv]
// Top level: longest well-formed parenthesis run over a character stream.
//
//  channel  | handshake           | payload
//  ---------+---------------------+------------------------------
//  in       | in_valid / in_ready | symbol[7:0], last
//  out      | out_valid/out_ready | longest_length[15:0], error
//
// One character request per cycle unless input is stalled; the result of the
// request carrying last passes the input register, then the result register.
// The stack top and the entry below it sit in registers; a pop refills the
// lower one from the stack memory with one registered read.
// Reset clears counters and flags; no clearing pass over the stack memory.
// Only a last request that meets a full, unread result register stalls input.
`default_nettype none

`include "assert_macros.svh"

module longest_valid_paren_run
    import lvpr_pkg::*;
#(
    parameter int STACK_DEPTH = DEF_STACK_DEPTH,
    parameter int MAX_STRING  = DEF_MAX_STRING
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [SYM_W-1:0] symbol,
    input  wire logic             last,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [LEN_W-1:0]      longest_length,
    output logic                  error
);

    localparam logic [LEN_W-1:0] MAX_POS = LEN_W'(MAX_STRING);

    logic             in_valid_reg;
    logic             in_valid_next;
    logic [SYM_W-1:0] symbol_reg;
    logic             last_reg;
    logic             advance;

    logic [LEN_W-1:0] pos_reg;
    logic [LEN_W-1:0] pos_next;
    logic [LEN_W-1:0] best_reg;
    logic [LEN_W-1:0] best_next;
    logic             err_reg;
    logic             err_next;

    logic [LEN_W-1:0] pos_upd;
    logic [LEN_W-1:0] best_upd;
    logic             err_upd;
    logic [LEN_W-1:0] cand;
    logic             is_open;

    logic             out_valid_reg;
    logic             out_valid_next;
    logic [LEN_W-1:0] len_reg;
    logic             err_out_reg;

    stk_ctl_t  stk_ctl;
    stk_stat_t stk_stat;

    lvpr_stack #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_stack (
        .clk  (clk),
        .rst_n(rst_n),
        .ctl  (stk_ctl),
        .stat (stk_stat)
    );

    assign advance  = in_valid_reg && (!last_reg || !out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;
    assign is_open  = (symbol_reg == OPEN_CHAR);

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_valid && in_ready)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance && last_reg)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        pos_upd       = pos_reg;
        best_upd      = best_reg;
        err_upd       = err_reg;
        cand          = '0;
        stk_ctl.push  = 1'b0;
        stk_ctl.pop   = 1'b0;
        stk_ctl.clear = 1'b0;
        stk_ctl.entry = {is_open, pos_reg};
        if (advance && !err_reg)
        begin
            if (pos_reg == MAX_POS)
            begin
                err_upd = 1'b1;
            end
            else
            begin
                pos_upd = pos_reg + LEN_W'(1);
                if (is_open || !stk_stat.top_open)
                begin
                    if (stk_stat.full)
                    begin
                        err_upd = 1'b1;
                    end
                    else
                    begin
                        stk_ctl.push = 1'b1;
                    end
                end
                else
                begin
                    stk_ctl.pop = 1'b1;
                    cand = stk_stat.single ? pos_reg + LEN_W'(1)
                                           : pos_reg - stk_stat.second_pos;
                    if (cand > best_reg)
                    begin
                        best_upd = cand;
                    end
                end
            end
        end
        // drop all state at the end of a string
        if (advance && last_reg)
        begin
            stk_ctl.clear = 1'b1;
            pos_next      = '0;
            best_next     = '0;
            err_next      = 1'b0;
        end
        else
        begin
            pos_next  = pos_upd;
            best_next = best_upd;
            err_next  = err_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_reg       <= '0;
            best_reg      <= '0;
            err_reg       <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            pos_reg       <= pos_next;
            best_reg      <= best_next;
            err_reg       <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            symbol_reg <= symbol;
            last_reg   <= last;
        end
        if (advance && last_reg)
        begin
            len_reg     <= best_upd;
            err_out_reg <= err_upd;
        end
    end

    assign out_valid      = out_valid_reg;
    assign longest_length = len_reg;
    assign error          = err_out_reg;

    `ASSERT_ALWAYS(a_pos_limit, clk, rst_n, pos_reg <= MAX_POS)
    `ASSERT_ALWAYS(a_best_le_pos, clk, rst_n, best_reg <= pos_reg)
    `ASSERT_IMPLIES(a_stall_cause, clk, rst_n, !in_ready, in_valid_reg && last_reg && out_valid_reg && !out_ready)

endmodule

`default_nettype wire

[hdl/lvpr_stack.sv]
// Pending-entry stack: memory plus cached top and second entries.
`default_nettype none

`include "assert_macros.svh"

module lvpr_stack
    import lvpr_pkg::*;
#(
    parameter int STACK_DEPTH = DEF_STACK_DEPTH
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire stk_ctl_t  ctl,
    output stk_stat_t      stat
);

    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = $clog2(STACK_DEPTH);

    logic [ENTRY_W-1:0] mem [STACK_DEPTH];
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [CNT_W-1:0]   rd_idx;
    logic [ENTRY_W-1:0] top_reg;
    logic [ENTRY_W-1:0] second_reg;

    assign rd_idx = count_reg - CNT_W'(3);

    always_comb
    begin
        count_next = count_reg;
        if (ctl.clear)
        begin
            count_next = '0;
        end
        else if (ctl.push)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (ctl.pop)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // write every push to memory; refill the second slot from memory on pop
    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            mem[count_reg[ADDR_W-1:0]] <= ctl.entry;
            top_reg                    <= ctl.entry;
            second_reg                 <= top_reg;
        end
        else if (ctl.pop)
        begin
            top_reg    <= second_reg;
            second_reg <= mem[rd_idx[ADDR_W-1:0]];
        end
    end

    assign stat.full       = (count_reg == CNT_W'(STACK_DEPTH));
    assign stat.single     = (count_reg == CNT_W'(1));
    assign stat.top_open   = (count_reg != '0) && top_reg[OPEN_BIT];
    assign stat.second_pos = second_reg[LEN_W-1:0];

    `ASSERT_ALWAYS(a_push_pop_excl, clk, rst_n, !(ctl.push && ctl.pop))
    `ASSERT_IMPLIES(a_pop_nonempty, clk, rst_n, ctl.pop, count_reg != '0)
    `ASSERT_NEXT(a_push_count, clk, rst_n, ctl.push && !ctl.clear, count_reg == $past(count_reg) + CNT_W'(1))

endmodule

`default_nettype wire

[tb/longest_valid_paren_run_test.sv]
// Self-checking testbench for longest_valid_paren_run: scripted and random text, predicted runs.
`default_nettype none

module longest_valid_paren_run_test;
    import lvpr_pkg::*;

    localparam logic [SYM_W-1:0] CLOSE_CHAR = 8'h29;
    localparam int unsigned RANDOM_CHARS = 490;
    localparam int unsigned STEADY_TAIL = 150;
    localparam int unsigned STALL_LIMIT = 1000;
    localparam int unsigned SCRIPT_ROWS = 19;

    typedef struct packed {
        logic             open;
        logic [LEN_W-1:0] pos;
    } paren_entry_t;

    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic             err;
    } paren_result_t;

    typedef struct packed {
        logic [SYM_W-1:0] sym_a;
        logic [SYM_W-1:0] sym_b;
        logic [16:0]      reps;
        logic             fin;
        logic             typed;
        logic [LEN_W-1:0] len;
        logic             err;
    } script_row_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    logic [SYM_W-1:0] symbol = '0;
    logic             last = 1'b0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    logic [LEN_W-1:0] longest_length;
    logic             error;

    paren_entry_t  paren_stack [DEF_STACK_DEPTH];
    int unsigned   depth_cnt = 0;
    int unsigned   next_pos = 0;
    int unsigned   best_run = 0;
    bit            overflowed = 1'b0;

    paren_result_t run_results_due [$];
    paren_result_t due;
    int unsigned   fault_count = 0;
    int unsigned   results_checked = 0;
    int unsigned   texts_sent = 0;
    int unsigned   chars_sent = 0;
    int unsigned   stalled_cycles = 0;
    int unsigned   stall_left = 0;
    bit            steady_flow = 1'b0;

    script_row_t script [SCRIPT_ROWS] = '{
        '{OPEN_CHAR,  OPEN_CHAR,  17'd1,     1'b1, 1'b1, 16'd0,     1'b0},
        '{CLOSE_CHAR, CLOSE_CHAR, 17'd1,     1'b1, 1'b1, 16'd0,     1'b0},
        '{OPEN_CHAR,  CLOSE_CHAR, 17'd2,     1'b1, 1'b1, 16'd2,     1'b0},
        '{OPEN_CHAR,  8'hFF,      17'd2,     1'b1, 1'b1, 16'd2,     1'b0},
        '{OPEN_CHAR,  8'h00,      17'd4,     1'b1, 1'b1, 16'd4,     1'b0},
        '{CLOSE_CHAR, OPEN_CHAR,  17'd3,     1'b0, 1'b0, 16'd0,     1'b0},
        '{OPEN_CHAR,  CLOSE_CHAR, 17'd2,     1'b1, 1'b0, 16'd0,     1'b0},
        '{OPEN_CHAR,  OPEN_CHAR,  17'd2,     1'b0, 1'b0, 16'd0,     1'b0},
        '{CLOSE_CHAR, CLOSE_CHAR, 17'd1,     1'b1, 1'b0, 16'd0,     1'b0},
        '{OPEN_CHAR,  8'h27,      17'd2,     1'b1, 1'b0, 16'd0,     1'b0},
        '{OPEN_CHAR,  CLOSE_CHAR, 17'd2,     1'b0, 1'b0, 16'd0,     1'b0},
        '{CLOSE_CHAR, CLOSE_CHAR, 17'd1,     1'b0, 1'b0, 16'd0,     1'b0},
        '{OPEN_CHAR,  CLOSE_CHAR, 17'd4,     1'b1, 1'b0, 16'd0,     1'b0},
        '{OPEN_CHAR,  8'hA8,      17'd2,     1'b0, 1'b0, 16'd0,     1'b0},
        '{OPEN_CHAR,  CLOSE_CHAR, 17'd2,     1'b1, 1'b0, 16'd0,     1'b0},
        '{OPEN_CHAR,  CLOSE_CHAR, 17'd2,     1'b0, 1'b0, 16'd0,     1'b0},
        '{OPEN_CHAR,  OPEN_CHAR,  17'd1025,  1'b0, 1'b0, 16'd0,     1'b0},
        '{CLOSE_CHAR, CLOSE_CHAR, 17'd1,     1'b1, 1'b1, 16'd2,     1'b1},
        '{OPEN_CHAR,  CLOSE_CHAR, 17'd2,     1'b1, 1'b1, 16'd2,     1'b0}
    };

    longest_valid_paren_run dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .symbol         (symbol),
        .last           (last),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .longest_length (longest_length),
        .error          (error)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic void push_paren(input logic is_open, input int unsigned at);
        if (depth_cnt >= DEF_STACK_DEPTH)
            overflowed = 1'b1;
        else
        begin
            paren_stack[depth_cnt] = '{is_open, at[LEN_W-1:0]};
            depth_cnt++;
        end
    endfunction

    function automatic bit track_symbol(input logic [SYM_W-1:0] sym, input logic fin,
                                        output paren_result_t run);
        int unsigned here;
        int unsigned span;
        run = '0;
        if (!overflowed)
        begin
            if (next_pos >= DEF_MAX_STRING)
                overflowed = 1'b1;
            else
            begin
                here = next_pos;
                next_pos++;
                if (sym == OPEN_CHAR)
                    push_paren(1'b1, here);
                else if (depth_cnt > 0 && paren_stack[depth_cnt - 1].open)
                begin
                    depth_cnt--;
                    span = (depth_cnt == 0) ? here + 1 : here - paren_stack[depth_cnt - 1].pos;
                    if (span > best_run)
                        best_run = span;
                end
                else
                    push_paren(1'b0, here);
            end
        end
        if (!fin)
            return 1'b0;
        run.len = best_run[LEN_W-1:0];
        run.err = overflowed;
        depth_cnt = 0;
        next_pos = 0;
        best_run = 0;
        overflowed = 1'b0;
        return 1'b1;
    endfunction

    task automatic send_char(input logic [SYM_W-1:0] sym, input logic fin, input logic typed,
                             input logic [LEN_W-1:0] typed_len, input logic typed_err);
        paren_result_t run;
        paren_result_t want;
        if (!steady_flow && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        in_valid <= 1'b1;
        symbol <= sym;
        last <= fin;
        do @(posedge clk); while (!in_ready);
        chars_sent++;
        if (track_symbol(sym, fin, run))
        begin
            want = typed ? paren_result_t'{typed_len, typed_err} : run;
            run_results_due = {run_results_due, want};
            texts_sent++;
        end
        @(negedge clk);
    endtask

    task automatic drain_results();
        if (run_results_due.size() != 0)
        begin
            in_valid <= 1'b0;
            while (run_results_due.size() != 0)
                @(negedge clk);
        end
    endtask

    task automatic send_random_text(input int unsigned text_len, input bit well_formed);
        int unsigned depth;
        logic [SYM_W-1:0] ch;
        depth = 0;
        for (int unsigned i = 0; i < text_len; i++)
        begin
            if (!well_formed)
            begin
                case ($urandom_range(0, 2))
                    0: ch = OPEN_CHAR;
                    1: ch = CLOSE_CHAR;
                    default: ch = SYM_W'($urandom_range(0, 255));
                endcase
            end
            else if (depth + 1 < text_len - i && (depth == 0 || $urandom_range(0, 1) == 0))
            begin
                ch = OPEN_CHAR;
                depth++;
            end
            else
            begin
                ch = CLOSE_CHAR;
                if ($urandom_range(0, 3) == 0)
                begin
                    ch = SYM_W'($urandom_range(0, 255));
                    if (ch == OPEN_CHAR)
                        ch = CLOSE_CHAR;
                end
                if (depth > 0)
                    depth--;
            end
            send_char(ch, i == text_len - 1, 1'b0, '0, 1'b0);
        end
    endtask

    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (!steady_flow && $urandom_range(0, 5) == 0)
        begin
            out_ready <= 1'b0;
            stall_left <= $urandom_range(0, 7);
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (run_results_due.size() == 0)
            begin
                $error("unexpected result: longest_length=%0d error=%0b", longest_length, error);
                fault_count++;
            end
            else
            begin
                due = run_results_due.pop_front();
                if (longest_length !== due.len)
                begin
                    $error("longest_length: expected %0d, actual %0d", due.len, longest_length);
                    fault_count++;
                end
                if (error !== due.err)
                begin
                    $error("error: expected %0b, actual %0b", due.err, error);
                    fault_count++;
                end
                results_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            stalled_cycles <= 0;
        else if (stalled_cycles >= STALL_LIMIT)
        begin
            $display("FAIL longest_valid_paren_run");
            $finish;
        end
        else
            stalled_cycles <= stalled_cycles + 1;
    end

    initial
    begin
        int unsigned random_chars;
        int unsigned text_len;
        bit fin_item;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int r = 0; r < SCRIPT_ROWS; r++)
        begin
            for (int unsigned k = 0; k < script[r].reps; k++)
            begin
                fin_item = script[r].fin && (k == script[r].reps - 1);
                send_char(k[0] ? script[r].sym_b : script[r].sym_a, fin_item,
                          script[r].typed, script[r].len, script[r].err);
            end
        end
        drain_results();

        random_chars = chars_sent;
        while (chars_sent - random_chars < RANDOM_CHARS)
        begin
            steady_flow = (chars_sent - random_chars >= RANDOM_CHARS - STEADY_TAIL);
            if (!steady_flow && $urandom_range(0, 24) == 0)
                drain_results();
            text_len = ($urandom_range(0, 15) == 0) ? $urandom_range(40, 200)
                                                    : $urandom_range(1, 24);
            send_random_text(text_len, $urandom_range(0, 9) < 7);
        end

        drain_results();
        repeat (8) @(negedge clk);
        $display("Covered %0d strings over %0d characters: nesting, stray bytes,",
                 texts_sent, chars_sent);
        $display("a filled and overflowed stack; %0d results checked.", results_checked);
        if (fault_count == 0)
            $display("PASS longest_valid_paren_run");
        else
            $display("FAIL longest_valid_paren_run");
        $finish;
    end
endmodule

`default_nettype wire

[sim.f]
+incdir+hdl
hdl/lvpr_pkg.sv
hdl/lvpr_stack.sv
hdl/longest_valid_paren_run.sv
tb/longest_valid_paren_run_test.sv
